### hw/rtl/sitda_pkg.sv
// sitda_pkg: shared constants and types for the signed integer to decimal
// ASCII unit. Used by every module of the block.
`timescale 1ns / 1ps

package sitda_pkg;

	localparam int ValueW   = 32;
	localparam int DigitsN  = 10;
	localparam int BcdW     = 4 * DigitsN;
	localparam int CharW    = 8;
	localparam int NdigW    = 4;
	localparam int CntW     = $clog2(ValueW);
	localparam int QueueDepthDefault = 2;

	localparam logic [CharW-1:0] AsciiMinus = 8'h2D;
	localparam logic [CharW-1:0] AsciiZero  = 8'h30;

	// converted word handed from front to back
	typedef struct packed {
		logic              neg;
		logic              flag;
		logic [NdigW-1:0]  ndig;
		logic [BcdW-1:0]   bcd;
	} conv_t;

endpackage

### hw/rtl/sitda_front.sv
// sitda_front: accepts a signed word, forms its magnitude and converts it to
// BCD with one shift-and-add-3 step per cycle. Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [sitda_pkg::ValueW-1:0] value,
	input  logic                                static_target,
	output logic                                push,
	output sitda_pkg::conv_t                    push_word,
	input  logic                                full
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]                      state_q;
	logic [sitda_pkg::CntW-1:0]      cnt_q;
	logic [sitda_pkg::ValueW-1:0]    mag_q;
	logic [sitda_pkg::BcdW-1:0]      bcd_q;
	logic                            neg_q;
	logic                            flag_q;
	logic [sitda_pkg::BcdW-1:0]      bcd_adj;
	logic [sitda_pkg::NdigW-1:0]     ndig;
	logic                            accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		for (int i = 0; i < sitda_pkg::DigitsN; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// significant digit count, at least one
	always_comb begin
		ndig = sitda_pkg::NdigW'(1);
		for (int i = 1; i < sitda_pkg::DigitsN; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				ndig = sitda_pkg::NdigW'(i + 1);
			end
		end
	end

	assign push           = (state_q == ST_PUSH) && !full;
	assign push_word.neg  = neg_q;
	assign push_word.flag = flag_q;
	assign push_word.ndig = ndig;
	assign push_word.bcd  = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == sitda_pkg::CntW'(sitda_pkg::ValueW - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= value[sitda_pkg::ValueW-1];
			flag_q <= static_target;
			bcd_q  <= '0;
			if (value[sitda_pkg::ValueW-1]) begin
				mag_q <= sitda_pkg::ValueW'(0) - sitda_pkg::ValueW'(value);
			end else begin
				mag_q <= sitda_pkg::ValueW'(value);
			end
		end else if (state_q == ST_CONV) begin
			bcd_q <= {bcd_adj[sitda_pkg::BcdW-2:0], mag_q[sitda_pkg::ValueW-1]};
			mag_q <= {mag_q[sitda_pkg::ValueW-2:0], 1'b0};
		end
	end

endmodule

### hw/rtl/sitda_queue.sv
// sitda_queue: short FIFO of converted words between front and back.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_queue #(
	parameter int DEPTH = sitda_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sitda_pkg::conv_t push_word,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output sitda_pkg::conv_t pop_word
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sitda_pkg::conv_t  mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/sitda_back.sv
// sitda_back: with out_stall low, emits one ASCII character per cycle
// from queued converted words via an output register. Uses sitda_pkg.
`timescale 1ns / 1ps

module sitda_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              not_empty,
	input  sitda_pkg::conv_t                  pop_word,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sitda_pkg::CharW-1:0]       char_code,
	output logic                              static_target_out,
	output logic                              last
);

	logic                            busy_q;
	logic                            neg_q;
	logic                            flag_q;
	logic [sitda_pkg::NdigW-1:0]     idx_q;
	logic [sitda_pkg::BcdW-1:0]      bcd_q;
	logic                            out_valid_q;
	logic [sitda_pkg::CharW-1:0]     char_q;
	logic                            flag_out_q;
	logic                            last_q;
	logic                            out_free;
	logic [3:0]                      digit;

	assign out_free          = !out_valid_q || !out_stall;
	assign pop               = !busy_q && not_empty;
	assign digit             = bcd_q[idx_q*4 +: 4];
	assign out_valid         = out_valid_q;
	assign char_code         = char_q;
	assign static_target_out = flag_out_q;
	assign last              = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && out_free && !neg_q && idx_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			neg_q  <= pop_word.neg;
			flag_q <= pop_word.flag;
			bcd_q  <= pop_word.bcd;
			idx_q  <= pop_word.ndig - 1'b1;
		end else if (busy_q && out_free) begin
			flag_out_q <= flag_q;
			if (neg_q) begin
				char_q <= sitda_pkg::AsciiMinus;
				last_q <= 1'b0;
				neg_q  <= 1'b0;
			end else begin
				char_q <= sitda_pkg::AsciiZero + sitda_pkg::CharW'(digit);
				last_q <= (idx_q == '0);
				if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

endmodule

### hw/rtl/signed_int_to_decimal_ascii_unit.sv
// signed_int_to_decimal_ascii_unit: top level, front converter, word queue
// and character emitter. Depends on sitda_pkg, sitda_front, sitda_queue, sitda_back.
`timescale 1ns / 1ps

// Converts a signed 32-bit word to its decimal ASCII text, most significant
// character first, with a leading '-' for negative values, no leading zeros,
// '0' for zero and last set on the final character; static_target is copied
// to every character. The front takes a word, runs its shift-and-add-3
// binary-to-BCD loop, then hands the result to the queue, waiting while the
// queue is full; it accepts no new word until that handoff is done. The back
// emits one character per cycle while out_stall is low (1 to 11 per word)
// from an output register; with the queue between them the two run side by
// side, so unless out_stall holds the back, the loop sets the word rate.

module signed_int_to_decimal_ascii_unit #(
	parameter int QUEUE_DEPTH = sitda_pkg::QueueDepthDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [sitda_pkg::ValueW-1:0] value,
	input  logic                                static_target,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sitda_pkg::CharW-1:0]         char_code,
	output logic                                static_target_out,
	output logic                                last
);

	logic             push;
	logic             full;
	logic             pop;
	logic             not_empty;
	sitda_pkg::conv_t push_word;
	sitda_pkg::conv_t pop_word;

	sitda_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value         (value),
		.static_target (static_target),
		.push          (push),
		.push_word     (push_word),
		.full          (full)
	);

	sitda_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_word  (pop_word)
	);

	sitda_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.not_empty         (not_empty),
		.pop_word          (pop_word),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.char_code         (char_code),
		.static_target_out (static_target_out),
		.last              (last)
	);

endmodule
